FILE: rtl/core/reply_keyword_matcher_with_history_assert.svh
// ----------------------------------------------------------------------------
// Reply keyword matcher assertion macros
// Concurrent assertion wrappers. They expand to nothing when SYNTHESIS is set.
// ----------------------------------------------------------------------------
`ifndef REPLY_KEYWORD_MATCHER_WITH_HISTORY_ASSERT_SVH
`define REPLY_KEYWORD_MATCHER_WITH_HISTORY_ASSERT_SVH
`ifndef SYNTHESIS
// Checked only while out of reset.
`define RKM_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Checked at every edge, reset included.
`define RKM_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define RKM_ASSERT(label, prop, msg)
`define RKM_ASSERT_ALWAYS(label, prop, msg)
`endif
`endif

FILE: rtl/core/rkm_pkg.sv
// ----------------------------------------------------------------------------
// rkm_pkg
// Shared codes, keyword table and the command format of the matcher.
// ----------------------------------------------------------------------------
`default_nettype none

package rkm_pkg;

    // Operation codes of an input beat.
    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_READ = 1'b1;

    // Event codes of a result beat.
    localparam logic [2:0] EV_NONE      = 3'd0;
    localparam logic [2:0] EV_READY     = 3'd1;
    localparam logic [2:0] EV_NOT_READY = 3'd2;
    localparam logic [2:0] EV_ONLINE    = 3'd3;
    localparam logic [2:0] EV_STORE     = 3'd4;
    localparam logic [2:0] EV_READ      = 3'd5;

    localparam logic [7:0] END_MARK = 8'h5E;

    // Widths that cover the whole supported parameter range.
    localparam int SLOT_W_MAX = 4;
    localparam int POS_W_MAX  = 8;

    // Command queue depth, a power of two.
    localparam int Q_DEPTH = 4;

    localparam int KW_COUNT = 12;
    localparam int KW_TEXT_W = 128;

    // Keyword strings, right aligned: the first character is the most
    // significant nonzero byte. The underscore is written as an octal escape.
    localparam logic [KW_TEXT_W-1:0] KW_TEXT [KW_COUNT] = '{
        "RDY1^", "\012RDY1", "Not\137RDY1^", "\015\012Node 1 Online",
        "RDY2^", "\012RDY2", "Not\137RDY2^", "\015\012Node 2 Online",
        "RDY3^", "\012RDY3", "Not\137RDY3^", "\015\012Node 3 Online"
    };

    localparam logic [3:0] KW_LEN [KW_COUNT] = '{
        4'd5, 4'd5, 4'd9, 4'd15,
        4'd5, 4'd5, 4'd9, 4'd15,
        4'd5, 4'd5, 4'd9, 4'd15
    };

    localparam logic [2:0] KW_EVENT [KW_COUNT] = '{
        EV_READY, EV_READY, EV_NOT_READY, EV_ONLINE,
        EV_READY, EV_READY, EV_NOT_READY, EV_ONLINE,
        EV_READY, EV_READY, EV_NOT_READY, EV_ONLINE
    };

    localparam logic [1:0] KW_NODE [KW_COUNT] = '{
        2'd1, 2'd1, 2'd1, 2'd1,
        2'd2, 2'd2, 2'd2, 2'd2,
        2'd3, 2'd3, 2'd3, 2'd3
    };

    localparam logic [2:0] KW_MASK [KW_COUNT] = '{
        3'b001, 3'b001, 3'b001, 3'b001,
        3'b010, 3'b010, 3'b010, 3'b010,
        3'b100, 3'b100, 3'b100, 3'b100
    };

    // One entry of the queue between classifier and executor.
    typedef struct packed {
        logic                  wr;
        logic                  rd;
        logic                  hit;
        logic [SLOT_W_MAX-1:0] slot;
        logic [POS_W_MAX-1:0]  pos;
        logic [7:0]            wdata;
        logic [2:0]            ev;
        logic [1:0]            node;
        logic [2:0]            mask;
        logic [6:0]            len;
    } cmd_t;

    // Character p of keyword k, zero past its end.
    function automatic logic [7:0] kw_char(input int k, input logic [7:0] p);
        logic [KW_TEXT_W-1:0] text;
        int                   sh;
        logic [7:0]           ch;
        text = KW_TEXT[k];
        ch   = 8'h00;
        if (p < 8'(KW_LEN[k]))
        begin
            sh = int'(KW_LEN[k]) - 1 - int'(p);
            ch = text[8*sh +: 8];
        end
        return ch;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/core/rkm_front.sv
// ----------------------------------------------------------------------------
// rkm_front
// Classifies each accepted beat: keyword tracking, ready flags, history
// line bookkeeping. Emits one command per beat for the executor.
// ----------------------------------------------------------------------------
`default_nettype none

`include "reply_keyword_matcher_with_history_assert.svh"

module rkm_front #(
    parameter int MSG_LEN       = 128,
    parameter int HISTORY_LINES = 4
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          accept,
    input  wire logic          op,
    input  wire logic [7:0]    rx_byte,
    input  wire logic [1:0]    line_sel,
    input  wire logic [6:0]    char_index,
    output rkm_pkg::cmd_t      cmd
);

    // One physical slot more than visible lines: the extra slot collects
    // the message being received.
    localparam int SLOTS  = HISTORY_LINES + 1;
    localparam int SLOT_W = $clog2(SLOTS);
    localparam int POS_W  = $clog2(MSG_LEN);
    localparam int CMP_W  = (POS_W > 7) ? POS_W : 7;
    localparam int SW     = rkm_pkg::SLOT_W_MAX;
    localparam int PW     = rkm_pkg::POS_W_MAX;
    localparam int KWN    = rkm_pkg::KW_COUNT;

    localparam logic [POS_W-1:0]  LAST_POS  = POS_W'(MSG_LEN - 1);
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(SLOTS - 1);

    logic [POS_W-1:0]  count_reg, count_next;
    logic [KWN-1:0]    alive_reg, alive_next;
    logic [2:0]        flags_reg, flags_next;
    logic [SLOT_W-1:0] newest_reg, newest_next;
    logic [POS_W-1:0]  len_reg [SLOTS];

    logic [SLOT_W-1:0] wslot;
    logic [SLOT_W-1:0] rslot;
    logic [SLOT_W:0]   sel_ext;
    logic [SLOT_W:0]   newest_ext;
    logic [SLOT_W:0]   rdiff;
    logic              sel_ok;
    logic [POS_W-1:0]  rlen;
    logic              hit;
    logic              can_app;
    logic [KWN-1:0]    alive_hit;
    logic              found;
    logic              commit;

    assign wslot      = (newest_reg == LAST_SLOT) ? '0 : newest_reg + 1'b1;
    assign sel_ext    = (SLOT_W+1)'(line_sel);
    assign newest_ext = {1'b0, newest_reg};
    assign rdiff      = (newest_ext >= sel_ext) ? newest_ext - sel_ext
                      : newest_ext + (SLOT_W+1)'(SLOTS) - sel_ext;
    assign rslot      = rdiff[SLOT_W-1:0];
    assign sel_ok     = sel_ext < (SLOT_W+1)'(HISTORY_LINES);
    assign rlen       = sel_ok ? len_reg[rslot] : '0;
    assign hit        = CMP_W'(char_index) < CMP_W'(rlen);
    assign can_app    = count_reg < LAST_POS;

    always_comb
    begin
        for (int k = 0; k < KWN; k++)
        begin
            alive_hit[k] = alive_reg[k]
                && (count_reg < POS_W'(rkm_pkg::KW_LEN[k]))
                && (rkm_pkg::kw_char(k, 8'(count_reg)) == rx_byte);
        end
    end

    always_comb
    begin
        cmd         = '0;
        count_next  = count_reg;
        alive_next  = alive_reg;
        flags_next  = flags_reg;
        newest_next = newest_reg;
        found       = 1'b0;
        commit      = 1'b0;
        if (accept)
        begin
            if (op == rkm_pkg::OP_READ)
            begin
                cmd.ev   = rkm_pkg::EV_READ;
                cmd.rd   = 1'b1;
                cmd.slot = SW'(rslot);
                cmd.pos  = PW'(char_index);
                cmd.hit  = hit;
                cmd.len  = 7'(rlen);
            end
            else if (rx_byte != 8'h00)
            begin
                if (can_app)
                begin
                    cmd.wr     = 1'b1;
                    cmd.slot   = SW'(wslot);
                    cmd.pos    = PW'(count_reg);
                    cmd.wdata  = rx_byte;
                    count_next = count_reg + 1'b1;
                    alive_next = alive_hit;
                    for (int k = 0; k < KWN; k++)
                    begin
                        if (!found && alive_hit[k]
                            && (POS_W'(rkm_pkg::KW_LEN[k]) == count_reg + 1'b1))
                        begin
                            found    = 1'b1;
                            cmd.ev   = rkm_pkg::KW_EVENT[k];
                            cmd.node = rkm_pkg::KW_NODE[k];
                            case (rkm_pkg::KW_EVENT[k])
                                rkm_pkg::EV_READY:
                                    flags_next = flags_reg | rkm_pkg::KW_MASK[k];
                                rkm_pkg::EV_NOT_READY:
                                    flags_next = flags_reg & ~rkm_pkg::KW_MASK[k];
                                default:
                                    flags_next = flags_reg;
                            endcase
                            count_next = '0;
                            alive_next = '1;
                        end
                    end
                end
                // The message is everything before the end mark, which is
                // the old fill level whether or not the mark was appended.
                if (!found && rx_byte == rkm_pkg::END_MARK)
                begin
                    commit      = 1'b1;
                    cmd.ev      = rkm_pkg::EV_STORE;
                    cmd.len     = 7'(count_reg);
                    newest_next = wslot;
                    count_next  = '0;
                    alive_next  = '1;
                end
            end
        end
        cmd.mask = flags_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            alive_reg  <= '1;
            flags_reg  <= '0;
            newest_reg <= '0;
            for (int i = 0; i < SLOTS; i++)
            begin
                len_reg[i] <= '0;
            end
        end
        else
        begin
            count_reg  <= count_next;
            alive_reg  <= alive_next;
            flags_reg  <= flags_next;
            newest_reg <= newest_next;
            if (commit)
            begin
                len_reg[wslot] <= count_reg;
            end
        end
    end

    `RKM_ASSERT(a_store_clears, accept && cmd.ev == rkm_pkg::EV_STORE |=> count_reg == '0, "store did not clear the receive buffer")
    `RKM_ASSERT(a_flags_idle, !accept |=> flags_reg == $past(flags_reg), "ready flags changed without a beat")
    `RKM_ASSERT(a_count_bound, count_reg <= LAST_POS, "receive count beyond buffer size")

endmodule

`default_nettype wire

FILE: rtl/core/rkm_queue.sv
// ----------------------------------------------------------------------------
// rkm_queue
// Short in-order command queue between classifier and executor.
// ----------------------------------------------------------------------------
`default_nettype none

`include "reply_keyword_matcher_with_history_assert.svh"

module rkm_queue (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    input  wire rkm_pkg::cmd_t din,
    output logic               full,
    input  wire logic          pop,
    output logic               valid,
    output rkm_pkg::cmd_t      dout
);

    localparam int DEPTH = rkm_pkg::Q_DEPTH;
    localparam int PTR_W = $clog2(DEPTH);

    rkm_pkg::cmd_t    entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [PTR_W:0]   cnt_reg, cnt_next;

    assign full  = cnt_reg == (PTR_W+1)'(DEPTH);
    assign valid = cnt_reg != '0;
    assign dout  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        case ({push, pop})
            2'b10:   cnt_next = cnt_reg + 1'b1;
            2'b01:   cnt_next = cnt_reg - 1'b1;
            default: cnt_next = cnt_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= din;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    `RKM_ASSERT(a_no_overflow, push |-> !full, "push into a full queue")
    `RKM_ASSERT(a_count_step, push && !pop |=> cnt_reg == $past(cnt_reg) + 1'b1, "queue count did not advance on push")

endmodule

`default_nettype wire

FILE: rtl/core/rkm_back.sv
// ----------------------------------------------------------------------------
// rkm_back
// Executes queued commands against the history memory and holds the
// result beat in the output register.
// ----------------------------------------------------------------------------
`default_nettype none

`include "reply_keyword_matcher_with_history_assert.svh"

module rkm_back #(
    parameter int MSG_LEN       = 128,
    parameter int HISTORY_LINES = 4
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          q_valid,
    input  wire rkm_pkg::cmd_t q_cmd,
    output logic               pop,
    output logic               out_valid,
    input  wire logic          out_stall,
    output logic [2:0]         event_res,
    output logic [1:0]         node,
    output logic [2:0]         ready_mask,
    output logic [6:0]         msg_length,
    output logic [7:0]         read_char
);

    localparam int SLOTS  = HISTORY_LINES + 1;
    localparam int SLOT_W = $clog2(SLOTS);
    localparam int POS_W  = $clog2(MSG_LEN);

    logic [7:0] mem [SLOTS][MSG_LEN];

    logic              out_valid_reg;
    logic [2:0]        ev_reg;
    logic [1:0]        node_reg;
    logic [2:0]        mask_reg;
    logic [6:0]        len_reg;
    logic              hit_reg;
    logic [7:0]        rdata_reg;
    logic [SLOT_W-1:0] slot;
    logic [POS_W-1:0]  pos;

    assign pop  = q_valid && (!out_valid_reg || !out_stall);
    assign slot = q_cmd.slot[SLOT_W-1:0];
    assign pos  = q_cmd.pos[POS_W-1:0];

    always_ff @(posedge clk)
    begin
        if (pop && q_cmd.wr)
        begin
            mem[slot][pos] <= q_cmd.wdata;
        end
        if (pop && q_cmd.rd)
        begin
            rdata_reg <= mem[slot][pos];
        end
        if (pop)
        begin
            ev_reg   <= q_cmd.ev;
            node_reg <= q_cmd.node;
            mask_reg <= q_cmd.mask;
            len_reg  <= q_cmd.len;
            hit_reg  <= q_cmd.rd && q_cmd.hit;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (pop)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign out_valid  = out_valid_reg;
    assign event_res  = ev_reg;
    assign node       = node_reg;
    assign ready_mask = mask_reg;
    assign msg_length = len_reg;
    assign read_char  = hit_reg ? rdata_reg : 8'h00;

    `RKM_ASSERT(a_hit_is_read, out_valid_reg && hit_reg |-> ev_reg == rkm_pkg::EV_READ, "character data on a non-read beat")

endmodule

`default_nettype wire

FILE: rtl/core/reply_keyword_matcher_with_history.sv
// ----------------------------------------------------------------------------
// reply_keyword_matcher_with_history
// Byte-stream keyword matcher with a ring of stored message lines.
// ----------------------------------------------------------------------------
// Usage: the input channel (in_valid / in_stall) carries one beat per
// received byte (op = 0) or per history read (op = 1). Every accepted beat
// produces exactly one result beat on the output channel (out_valid /
// out_stall), in order. Results for a received byte report keyword events,
// stored messages and the current ready mask; read beats return one
// character of a history line plus its length.
// A beat is classified and queued at the edge that accepts it, and the
// executor moves it into the output register once that register is free
// or being taken by the receiver. Throughput is one beat per cycle while
// the receiver does not stall; each beat uses the single history memory
// port at most once in the executor.
// When the receiver stalls, the output register holds its beat and the
// four-entry command queue fills; in_stall rises once the queue is full.
// Reset clears the receive buffer, ready flags and all history line
// lengths at once; no clearing pass runs and the block accepts beats as
// soon as reset is released.
// ----------------------------------------------------------------------------
`default_nettype none

module reply_keyword_matcher_with_history #(
    parameter int MSG_LEN       = 128,
    parameter int HISTORY_LINES = 4
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire logic       op,
    input  wire logic [7:0] rx_byte,
    input  wire logic [1:0] line_sel,
    input  wire logic [6:0] char_index,
    output logic            out_valid,
    input  wire logic       out_stall,
    output logic [2:0]      event_res,
    output logic [1:0]      node,
    output logic [2:0]      ready_mask,
    output logic [6:0]      msg_length,
    output logic [7:0]      read_char
);

    // Front to back command path.
    rkm_pkg::cmd_t front_cmd;
    rkm_pkg::cmd_t q_cmd;
    logic          q_full;
    logic          q_valid;
    logic          q_pop;
    logic          accept;

    // A beat is taken whenever the queue has room; the classifier updates
    // its state in that same cycle, so the next byte may follow at once.
    assign in_stall = q_full;
    assign accept   = in_valid && !q_full;

    // The front tracks which keywords still match the buffer, the fill
    // level, the ready flags and the ring pointer. Received bytes are
    // written straight into the spare line of the ring, so storing a
    // message is only a pointer and length update.
    rkm_front #(
        .MSG_LEN       (MSG_LEN),
        .HISTORY_LINES (HISTORY_LINES)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .op         (op),
        .rx_byte    (rx_byte),
        .line_sel   (line_sel),
        .char_index (char_index),
        .cmd        (front_cmd)
    );

    rkm_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (accept),
        .din   (front_cmd),
        .full  (q_full),
        .pop   (q_pop),
        .valid (q_valid),
        .dout  (q_cmd)
    );

    // The back owns the history memory and the output register.
    rkm_back #(
        .MSG_LEN       (MSG_LEN),
        .HISTORY_LINES (HISTORY_LINES)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_valid    (q_valid),
        .q_cmd      (q_cmd),
        .pop        (q_pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .event_res  (event_res),
        .node       (node),
        .ready_mask (ready_mask),
        .msg_length (msg_length),
        .read_char  (read_char)
    );

endmodule

`default_nettype wire

FILE: sim/reply_keyword_matcher_with_history_tb.sv
// ----------------------------------------------------------------------------
// reply_keyword_matcher_with_history_tb
// Self-checking bench for the reply keyword matcher. A queue of byte and
// history-read beats is built up front: a short directed opening, then
// random keyword replies, messages, broken keywords, noise and reads. A
// clocked driver and a stall process apply random gaps on both channels. A
// monitor keeps its own model of the receive buffer, the keyword tracking,
// the ready flags and the history ring, and checks every result beat field
// by field.
// ----------------------------------------------------------------------------

module reply_keyword_matcher_with_history_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MSG_CAP      = 128;   // receive buffer size, one slot kept free
    localparam int HIST_LINES   = 4;
    localparam int KW_NUM       = 12;    // four reply forms for each of three nodes
    localparam int RANDOM_BEATS = 950;
    localparam int HOLD_CYCLES  = 80;    // long receiver hold-off
    localparam int IDLE_LIMIT   = 2000;  // cycles without any beat before giving up
    localparam int MAX_PRINTS   = 40;

    // One input beat plus the way the driver should present it.
    typedef struct packed {
        logic       op;
        logic [7:0] rx_byte;
        logic [1:0] line_sel;
        logic [6:0] char_index;
        logic [3:0] gap;       // idle cycles before this beat is offered
        logic       drain;     // hold this beat until every result is back
    } beat_t;

    // One result beat as the block should present it.
    typedef struct packed {
        logic [2:0] ev;
        logic [1:0] node;
        logic [2:0] mask;
        logic [6:0] len;
        logic [7:0] ch;
    } reply_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_stall;
    logic       op = 1'b0;
    logic [7:0] rx_byte = 8'h00;
    logic [1:0] line_sel = 2'd0;
    logic [6:0] char_index = 7'd0;
    logic       out_valid;
    logic       out_stall = 1'b0;
    logic [2:0] event_res;
    logic [1:0] node;
    logic [2:0] ready_mask;
    logic [6:0] msg_length;
    logic [7:0] read_char;

    reply_keyword_matcher_with_history u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .op         (op),
        .rx_byte    (rx_byte),
        .line_sel   (line_sel),
        .char_index (char_index),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .event_res  (event_res),
        .node       (node),
        .ready_mask (ready_mask),
        .msg_length (msg_length),
        .read_char  (read_char)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Bench bookkeeping
    // ------------------------------------------------------------------------
    beat_t  beat_queue[$];        // beats not yet offered to the block
    reply_t expected_replies[$];  // predicted results, oldest first
    string  kw_str [KW_NUM];      // reply keyword texts, index = 4*(node-1)+form

    int beats_made;      // generated beats that the block does not just ignore
    int beats_taken;     // input beats accepted
    int beats_sent;      // input beats the driver has seen accepted
    int replies_taken;   // result beats accepted
    int mismatches;
    int idle_cycles;

    // ------------------------------------------------------------------------
    // Matcher model state
    // ------------------------------------------------------------------------
    logic [7:0]        rx_text [MSG_CAP];
    int                rx_fill = 0;
    logic [KW_NUM-1:0] kw_live = '1;   // keywords still consistent with the buffer
    logic [2:0]        ready_now = 3'b000;
    logic [7:0]        line_text [HIST_LINES][MSG_CAP];
    logic [6:0]        line_len [HIST_LINES];
    logic [1:0]        newest_line = 2'd0;

    initial
    begin
        for (int i = 0; i < HIST_LINES; i++)
            line_len[i] = 7'd0;
    end

    // Advance the model by one accepted beat and return the result it causes.
    function automatic reply_t predict_reply(input beat_t b);
        reply_t r;
        int     slot;
        int     p;
        int     mlen;
        bit     appended;
        bit     matched;
        r        = '0;
        appended = 1'b0;
        matched  = 1'b0;
        if (b.op == rkm_pkg::OP_READ)
        begin
            // Line 0 is the newest; older lines count backwards around the ring.
            r.ev  = rkm_pkg::EV_READ;
            slot  = (int'(newest_line) + HIST_LINES - int'(b.line_sel)) % HIST_LINES;
            r.len = line_len[slot];
            if (b.char_index < line_len[slot])
                r.ch = line_text[slot][b.char_index];
        end
        else if (b.rx_byte != 8'h00)
        begin
            // A full buffer drops the byte, so no keyword can complete on it.
            if (rx_fill < MSG_CAP - 1)
            begin
                p          = rx_fill;
                rx_text[p] = b.rx_byte;
                rx_fill    = p + 1;
                appended   = 1'b1;
                for (int k = 0; k < KW_NUM; k++)
                    if (kw_live[k] && !(p < kw_str[k].len() && kw_str[k][p] == b.rx_byte))
                        kw_live[k] = 1'b0;
                for (int k = 0; k < KW_NUM; k++)
                begin
                    if (!matched && kw_live[k] && kw_str[k].len() == rx_fill)
                    begin
                        matched = 1'b1;
                        r.node  = 2'(k / 4 + 1);
                        case (k % 4)
                            0, 1:
                            begin
                                r.ev = rkm_pkg::EV_READY;
                                ready_now[k / 4] = 1'b1;
                            end
                            2:
                            begin
                                r.ev = rkm_pkg::EV_NOT_READY;
                                ready_now[k / 4] = 1'b0;
                            end
                            default:
                                r.ev = rkm_pkg::EV_ONLINE;
                        endcase
                        rx_fill = 0;
                        kw_live = '1;
                    end
                end
            end
            // An end mark that did not finish a keyword closes a message.
            // The mark itself is not part of the stored line.
            if (!matched && b.rx_byte == rkm_pkg::END_MARK)
            begin
                mlen        = appended ? rx_fill - 1 : rx_fill;
                newest_line = newest_line + 2'd1;
                for (int i = 0; i < mlen; i++)
                    line_text[newest_line][i] = rx_text[i];
                line_len[newest_line] = 7'(mlen);
                r.ev    = rkm_pkg::EV_STORE;
                r.len   = 7'(mlen);
                rx_fill = 0;
                kw_live = '1;
            end
        end
        r.mask = ready_now;
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        if (mismatches < MAX_PRINTS)
            $display("ERROR @%0t: %s", $realtime, msg);
        mismatches++;
    endtask

    task automatic check_field(input string name, input int got, input int want);
        if (got != want)
            report_mismatch($sformatf("reply %0d %s is %0d, expected %0d",
                                      replies_taken, name, got, want));
    endtask

    // ------------------------------------------------------------------------
    // Stimulus generation
    // ------------------------------------------------------------------------
    // Each beat gets its own sender gap. Beats 120 to 219 go back to back so
    // that the block also sees a stretch at full rate, and the beats made at
    // counts 450 and 850 wait for the block to drain completely first.
    task automatic push_beat(input logic op_v, input logic [7:0] b,
                             input logic [1:0] sel, input logic [6:0] idx);
        beat_t t;
        t.op         = op_v;
        t.rx_byte    = b;
        t.line_sel   = sel;
        t.char_index = idx;
        t.gap        = (beats_made >= 120 && beats_made < 220) ? 4'd0 :
                       4'($urandom_range(0, 8));
        t.drain      = (beats_made == 450 || beats_made == 850);
        beat_queue.push_back(t);
        if (op_v == rkm_pkg::OP_READ || b != 8'h00)
            beats_made++;
    endtask

    // The read fields ride along on byte beats with random content, and the
    // byte field does the same on read beats.
    task automatic push_byte(input logic [7:0] b);
        push_beat(rkm_pkg::OP_BYTE, b, 2'($urandom_range(0, 3)),
                  7'($urandom_range(0, 127)));
    endtask

    task automatic push_read(input logic [1:0] sel, input logic [6:0] idx);
        push_beat(rkm_pkg::OP_READ, 8'($urandom_range(0, 255)), sel, idx);
    endtask

    task automatic push_text(input string s);
        for (int i = 0; i < s.len(); i++)
            push_byte(s[i]);
    endtask

    // A message body never holds an end mark; now and then a zero byte is
    // mixed in, which the block must skip.
    task automatic push_message(input int n);
        logic [7:0] b;
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(0, 9) == 0)
                push_byte(8'h00);
            b = 8'($urandom_range(1, 255));
            if (b == rkm_pkg::END_MARK)
                b = b + 8'd1;
            push_byte(b);
        end
        push_byte(rkm_pkg::END_MARK);
    endtask

    task automatic build_stimulus();
        int    pick;
        int    k;
        int    n;
        int    cut;
        int    long_done;
        string s;
        long_done = 0;

        // Directed opening. The history is empty after reset, so even the
        // newest line reads back with zero length.
        push_read(2'd0, 7'd0);
        push_byte(8'h00);                 // zero byte: ignored
        push_byte(rkm_pkg::END_MARK);     // lone end mark stores an empty line
        push_text(kw_str[4]);             // node 2 ready
        push_byte(8'h01);
        push_byte(8'hFF);
        push_byte(rkm_pkg::END_MARK);     // two-character message
        push_read(2'd0, 7'd1);
        push_read(2'd0, 7'd127);          // beyond the line length
        push_read(2'd3, 7'd0);
        push_read(2'd1, 7'd0);            // the empty line stored above
        push_text(kw_str[6]);             // node 2 not ready

        while (beats_made < RANDOM_BEATS)
        begin
            if ((long_done == 0 && beats_made >= 250) || (long_done == 1 && beats_made >= 600))
            begin
                // Long message around the buffer size: bytes past the last free
                // slot are dropped and the end mark still stores the buffer.
                push_message($urandom_range(126, 135));
                push_read(2'd0, 7'd126);
                for (int i = 0; i < 5; i++)
                    push_read(2'd0, 7'($urandom_range(0, 127)));
                long_done++;
            end
            else
            begin
                pick = $urandom_range(0, 99);
                if (pick < 30)
                    push_text(kw_str[$urandom_range(0, KW_NUM - 1)]);
                else if (pick < 55)
                    push_message($urandom_range(0, 20));
                else if (pick < 75)
                begin
                    n = $urandom_range(1, 4);
                    for (int i = 0; i < n; i++)
                        push_read(2'($urandom_range(0, 3)),
                                  $urandom_range(0, 1) ? 7'($urandom_range(0, 127)) :
                                                         7'($urandom_range(0, 15)));
                end
                else if (pick < 88)
                begin
                    // Keyword cut short by a random byte, then closed as a message.
                    k   = $urandom_range(0, KW_NUM - 1);
                    s   = kw_str[k];
                    cut = $urandom_range(1, s.len() - 1);
                    push_text(s.substr(0, cut - 1));
                    push_byte(8'($urandom_range(1, 255)));
                    push_byte(rkm_pkg::END_MARK);
                end
                else
                begin
                    // Raw noise; it may leave the buffer half full.
                    n = $urandom_range(1, 6);
                    for (int i = 0; i < n; i++)
                        push_byte(8'($urandom_range(0, 255)));
                end
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Sender: presents queued beats, honoring each beat's gap. A payload is
    // held until the beat is taken.
    // ------------------------------------------------------------------------
    int    gap_left = 0;
    beat_t cur_beat;

    always @(negedge clk)
    begin : drive_beats
        logic nv;
        if (rst_n)
        begin
            nv = in_valid;
            if (in_valid && beats_taken != beats_sent)
            begin
                beats_sent = beats_taken;
                nv         = 1'b0;
                if (beat_queue.size() > 0)
                    gap_left = beat_queue[0].gap;
            end
            if (!nv && beat_queue.size() > 0)
            begin
                if (gap_left > 0)
                    gap_left--;
                else if (!beat_queue[0].drain || expected_replies.size() == 0)
                begin
                    cur_beat   = beat_queue.pop_front();
                    op         <= cur_beat.op;
                    rx_byte    <= cur_beat.rx_byte;
                    line_sel   <= cur_beat.line_sel;
                    char_index <= cur_beat.char_index;
                    nv         = 1'b1;
                end
            end
            in_valid <= nv;
        end
    end

    // ------------------------------------------------------------------------
    // Receiver: after every result beat it stalls for a random number of
    // cycles. Results 100 to 219 are taken without stalls. Twice in the run it
    // holds off for a long stretch so that the command queue fills and the
    // block has to stall its input while the sender keeps offering beats.
    // ------------------------------------------------------------------------
    int replies_seen = 0;
    int stall_left = 0;
    int hold_left = 0;
    int holds_done = 0;

    always @(negedge clk)
    begin : drive_stall
        logic ns;
        if (rst_n)
        begin
            if (replies_taken != replies_seen)
            begin
                replies_seen = replies_taken;
                stall_left   = (replies_taken >= 100 && replies_taken < 220) ? 0 :
                               $urandom_range(0, 8);
            end
            if (holds_done < 2 && replies_taken >= 300 + 350 * holds_done)
            begin
                hold_left = HOLD_CYCLES;
                holds_done++;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                ns = 1'b1;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                ns = 1'b1;
            end
            else
                ns = 1'b0;
            out_stall <= ns;
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: checks each result beat against the oldest prediction, and
    // predicts the result of every input beat at the edge that takes it.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin : watch_ports
        reply_t want;
        beat_t  seen;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                replies_taken++;
                if (expected_replies.size() == 0)
                    report_mismatch($sformatf("reply %0d arrived with nothing outstanding",
                                              replies_taken));
                else
                begin
                    want = expected_replies.pop_front();
                    check_field("event_res", event_res, want.ev);
                    check_field("node", node, want.node);
                    check_field("ready_mask", ready_mask, want.mask);
                    check_field("msg_length", msg_length, want.len);
                    check_field("read_char", read_char, want.ch);
                end
            end
            if (in_valid && !in_stall)
            begin
                beats_taken++;
                seen            = '0;
                seen.op         = op;
                seen.rx_byte    = rx_byte;
                seen.line_sel   = line_sel;
                seen.char_index = char_index;
                expected_replies.push_back(predict_reply(seen));
            end
        end
    end

    // Watchdog: the run is considered hung after a long stretch in which
    // neither channel moves a beat.
    always @(posedge clk)
    begin
        if (rst_n && !((in_valid && !in_stall) || (out_valid && !out_stall)))
            idle_cycles++;
        else
            idle_cycles = 0;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("reply_keyword_matcher_with_history: mismatch");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Run control
    // ------------------------------------------------------------------------
    initial
    begin
        for (int k = 0; k < KW_NUM; k++)
        begin
            case (k % 4)
                0:       kw_str[k] = $sformatf("RDY%0d^", k / 4 + 1);
                1:       kw_str[k] = $sformatf("\nRDY%0d", k / 4 + 1);
                2:       kw_str[k] = $sformatf("Not_RDY%0d^", k / 4 + 1);
                default: kw_str[k] = $sformatf("\r\nNode %0d Online", k / 4 + 1);
            endcase
        end
        build_stimulus();

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Wait for the last beat to be taken and its result to come back,
        // then a few more cycles to catch any stray result.
        while (beat_queue.size() != 0 || in_valid || expected_replies.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (expected_replies.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", expected_replies.size()));

        if (mismatches == 0)
            $display("reply_keyword_matcher_with_history: match");
        else
            $display("reply_keyword_matcher_with_history: mismatch");
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+rtl/core
rtl/core/rkm_pkg.sv
rtl/core/rkm_front.sv
rtl/core/rkm_queue.sv
rtl/core/rkm_back.sv
rtl/core/reply_keyword_matcher_with_history.sv
sim/reply_keyword_matcher_with_history_tb.sv
